FILE: rtl/core/tprl_pkg.sv
package tprl_pkg;

    localparam int STATIC_DEPTH_DEF  = 16;
    localparam int LEARNED_DEPTH_DEF = 64;
    localparam int PORT_COUNT        = 16;

    localparam int IN_DATA_W  = 152;
    localparam int IN_USER_W  = 2;
    localparam int OUT_DATA_W = 56;
    localparam int OUT_USER_W = 3;

    typedef enum logic [1:0] {
        MODE_ADD_STATIC  = 2'd0,
        MODE_ADD_LEARNED = 2'd1,
        MODE_CLEAR       = 2'd2,
        MODE_LOOKUP      = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        STATUS_OK       = 2'd0,
        STATUS_FULL     = 2'd1,
        STATUS_NO_ROUTE = 2'd2,
        STATUS_RSVD     = 2'd3
    } status_t;

    typedef struct packed {
        logic [3:0]  port;
        logic [47:0] hop;
        logic [31:0] mask;
        logic [31:0] prefix;
    } route_t;

endpackage

FILE: rtl/core/tprl_match.sv
module tprl_match
(
    input  tprl_pkg::route_t entry,
    input  logic [31:0]      addr,
    input  logic [31:0]      best_mask,
    output logic             better
);
    import tprl_pkg::*;

    assign better = (entry.prefix == (addr & entry.mask)) && (entry.mask > best_mask);

endmodule

FILE: rtl/core/two_tier_prefix_route_lookup_unit.sv
// Two-tier longest-prefix route lookup.
// Slave channel: one request per handshake. tuser holds the mode (add static route,
// append learned route, clear learned table, lookup); tdata holds the route fields
// and the lookup address. Master channel: one result per request, status and the
// learned flag in tuser, next hop MAC and port in tdata.
// Requests are taken one at a time; s_axis_tready is high only while idle.
// Add and clear requests go from idle straight to the response state. A lookup
// walks the static table and then, if no static route matched, the learned
// table, one entry per cycle through the read port of each table memory, and
// then presents the result on the master channel.
// Reset empties both tables (the entry counts go to zero) and returns to idle;
// table memories are not cleared, entries beyond the counts are never read.
// The result stays on the master channel until taken; while the receiver stalls
// no new request is accepted.
module two_tier_prefix_route_lookup_unit
#(
    parameter int STATIC_DEPTH  = tprl_pkg::STATIC_DEPTH_DEF,
    parameter int LEARNED_DEPTH = tprl_pkg::LEARNED_DEPTH_DEF
)
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // prefix, prefix_mask, new_next_hop, new_port, lookup_addr, zero pad
    input  logic [tprl_pkg::IN_DATA_W-1:0]  s_axis_tdata,
    // mode
    input  logic [tprl_pkg::IN_USER_W-1:0]  s_axis_tuser,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // next_hop_mac, out_port, zero pad
    output logic [tprl_pkg::OUT_DATA_W-1:0] m_axis_tdata,
    // status, from_learned
    output logic [tprl_pkg::OUT_USER_W-1:0] m_axis_tuser
);
    import tprl_pkg::*;

    localparam int SCW = $clog2(STATIC_DEPTH + 1);
    localparam int LCW = $clog2(LEARNED_DEPTH + 1);
    localparam int SIW = (STATIC_DEPTH > 1) ? $clog2(STATIC_DEPTH) : 1;
    localparam int LIW = (LEARNED_DEPTH > 1) ? $clog2(LEARNED_DEPTH) : 1;
    localparam int IW  = (SCW > LCW) ? SCW : LCW;

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_SCAN_S = 4'b0010,
        ST_SCAN_L = 4'b0100,
        ST_RESP   = 4'b1000
    } state_t;

    state_t        state_reg, state_next;
    logic [SCW-1:0] s_count_reg, s_count_next;
    logic [LCW-1:0] l_count_reg, l_count_next;
    logic [IW-1:0]  idx_reg, idx_next;
    logic           pend_reg, pend_next;
    logic           hit_reg, hit_next;
    logic [31:0]    best_mask_reg, best_mask_next;
    logic [47:0]    best_hop_reg, best_hop_next;
    logic [3:0]     best_port_reg, best_port_next;
    logic [31:0]    addr_reg, addr_next;
    status_t        status_reg, status_next;
    logic [47:0]    hop_reg, hop_next;
    logic [3:0]     port_reg, port_next;
    logic           learned_reg, learned_next;

    route_t         s_mem [STATIC_DEPTH];
    route_t         l_mem [LEARNED_DEPTH];
    route_t         s_q_reg, l_q_reg, cmp_entry, new_entry;
    logic           s_we, l_we, s_re, l_re, better;
    logic           accept, port_bad;
    mode_t          req_mode;

    assign accept        = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = (state_reg == ST_IDLE);
    assign m_axis_tvalid = (state_reg == ST_RESP);
    assign m_axis_tdata  = {4'b0000, port_reg, hop_reg};
    assign m_axis_tuser  = {learned_reg, status_reg};

    assign req_mode         = mode_t'(s_axis_tuser[1:0]);
    assign new_entry.prefix = s_axis_tdata[31:0];
    assign new_entry.mask   = s_axis_tdata[63:32];
    assign new_entry.hop    = s_axis_tdata[111:64];
    assign new_entry.port   = s_axis_tdata[115:112];
    assign port_bad         = (32'(s_axis_tdata[115:112]) >= PORT_COUNT);

    assign cmp_entry = (state_reg == ST_SCAN_L) ? l_q_reg : s_q_reg;

    tprl_match u_match
    (
        .entry     (cmp_entry),
        .addr      (addr_reg),
        .best_mask (best_mask_reg),
        .better    (better)
    );

    assign s_re = (state_reg == ST_SCAN_S) && (idx_reg < IW'(s_count_reg));
    assign l_re = (state_reg == ST_SCAN_L) && (idx_reg < IW'(l_count_reg));

    always_comb
    begin
        state_next     = state_reg;
        s_count_next   = s_count_reg;
        l_count_next   = l_count_reg;
        idx_next       = idx_reg;
        pend_next      = 1'b0;
        hit_next       = hit_reg;
        best_mask_next = best_mask_reg;
        best_hop_next  = best_hop_reg;
        best_port_next = best_port_reg;
        addr_next      = addr_reg;
        status_next    = status_reg;
        hop_next       = hop_reg;
        port_next      = port_reg;
        learned_next   = learned_reg;
        s_we           = 1'b0;
        l_we           = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    status_next  = STATUS_OK;
                    hop_next     = '0;
                    port_next    = '0;
                    learned_next = 1'b0;
                    state_next   = ST_RESP;
                    unique case (req_mode)
                        MODE_ADD_STATIC:
                        begin
                            if (s_count_reg >= SCW'(STATIC_DEPTH))
                                status_next = STATUS_FULL;
                            else if (port_bad)
                                status_next = STATUS_NO_ROUTE;
                            else
                            begin
                                s_we         = 1'b1;
                                s_count_next = s_count_reg + SCW'(1);
                            end
                        end
                        MODE_ADD_LEARNED:
                        begin
                            if (l_count_reg >= LCW'(LEARNED_DEPTH))
                                status_next = STATUS_FULL;
                            else if (port_bad)
                                status_next = STATUS_NO_ROUTE;
                            else
                            begin
                                l_we         = 1'b1;
                                l_count_next = l_count_reg + LCW'(1);
                            end
                        end
                        MODE_CLEAR:
                        begin
                            l_count_next = '0;
                        end
                        MODE_LOOKUP:
                        begin
                            addr_next      = s_axis_tdata[147:116];
                            idx_next       = '0;
                            hit_next       = 1'b0;
                            best_mask_next = '0;
                            best_hop_next  = '0;
                            best_port_next = '0;
                            state_next     = ST_SCAN_S;
                        end
                    endcase
                end
            end
            ST_SCAN_S, ST_SCAN_L:
            begin
                if (s_re || l_re)
                begin
                    idx_next  = idx_reg + IW'(1);
                    pend_next = 1'b1;
                end
                if (pend_reg && better)
                begin
                    hit_next       = 1'b1;
                    best_mask_next = cmp_entry.mask;
                    best_hop_next  = cmp_entry.hop;
                    best_port_next = cmp_entry.port;
                end
                if (!s_re && !l_re && !pend_reg)
                begin
                    if (state_reg == ST_SCAN_S && !hit_reg)
                    begin
                        idx_next   = '0;
                        state_next = ST_SCAN_L;
                    end
                    else
                    begin
                        state_next   = ST_RESP;
                        status_next  = hit_reg ? STATUS_OK : STATUS_NO_ROUTE;
                        hop_next     = best_hop_reg;
                        port_next    = best_port_reg;
                        learned_next = hit_reg && (state_reg == ST_SCAN_L);
                    end
                end
            end
            ST_RESP:
            begin
                if (m_axis_tready)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            s_count_reg <= '0;
            l_count_reg <= '0;
            pend_reg    <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            s_count_reg <= s_count_next;
            l_count_reg <= l_count_next;
            pend_reg    <= pend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg       <= idx_next;
        hit_reg       <= hit_next;
        best_mask_reg <= best_mask_next;
        best_hop_reg  <= best_hop_next;
        best_port_reg <= best_port_next;
        addr_reg      <= addr_next;
        status_reg    <= status_next;
        hop_reg       <= hop_next;
        port_reg      <= port_next;
        learned_reg   <= learned_next;
    end

    always_ff @(posedge clk)
    begin
        if (s_we)
            s_mem[s_count_reg[SIW-1:0]] <= new_entry;
        if (s_re)
            s_q_reg <= s_mem[idx_reg[SIW-1:0]];
    end

    always_ff @(posedge clk)
    begin
        if (l_we)
            l_mem[l_count_reg[LIW-1:0]] <= new_entry;
        if (l_re)
            l_q_reg <= l_mem[idx_reg[LIW-1:0]];
    end

endmodule
